### rtl/cpjc_pkg.sv
// ----------------------------------------------------------------------------
// cpjc_pkg
// Constants and fixed-point helpers for the cascade PI joint controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpjc_pkg;

  localparam int ONE_Q16          = 65536;
  localparam int VEL_LIMIT_MAX    = 45;
  localparam int TORQUE_LIMIT_MAX = 20;
  localparam int NCOEF            = 6;

  localparam logic [31:0] POS_KP_CAP  = 32'(100 * ONE_Q16);
  localparam logic [31:0] VEL_KP_CAP  = 32'(10 * ONE_Q16);
  localparam logic [31:0] VEL_KI_CAP  = 32'(100 * ONE_Q16);
  localparam logic [31:0] VEL_LIM_CAP = 32'(VEL_LIMIT_MAX * ONE_Q16);
  localparam logic [31:0] TRQ_LIM_CAP = 32'(TORQUE_LIMIT_MAX * ONE_Q16);

  localparam logic [23:0] DT_LO = 24'd1678;
  localparam logic [23:0] DT_HI = 24'd167772;

  // configuration register indexes
  localparam logic [1:0] CFG_COEF_AXIS   = 2'd0;
  localparam logic [1:0] CFG_COEF_SELECT = 2'd1;
  localparam logic [1:0] CFG_COEF_VALUE  = 2'd2;

  // coefficient selects
  localparam logic [2:0] SEL_POS_KP  = 3'd0;
  localparam logic [2:0] SEL_VEL_KP  = 3'd1;
  localparam logic [2:0] SEL_VEL_KI  = 3'd2;
  localparam logic [2:0] SEL_VEL_LIM = 3'd3;
  localparam logic [2:0] SEL_INT_LIM = 3'd4;
  localparam logic [2:0] SEL_TRQ_LIM = 3'd5;

  // request kinds
  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  function automatic logic [31:0] cap_coef(input logic [31:0] v, input logic [31:0] c);
    return (v > c) ? c : v;
  endfunction

  // divide by 2^16, truncating toward zero
  function automatic logic signed [47:0] div_q16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + (x[63] ? 64'sd65535 : 64'sd0);
    return t[63:16];
  endfunction

  // divide by 2^24, truncating toward zero
  function automatic logic signed [39:0] div_q24(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + (x[63] ? 64'sd16777215 : 64'sd0);
    return t[63:24];
  endfunction

  function automatic logic signed [47:0] sclamp(input logic signed [47:0] v,
                                                input logic [31:0] lim);
    logic signed [47:0] hi;
    hi = $signed({16'd0, lim});
    if (v > hi) return hi;
    if (v < -hi) return -hi;
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/cascade_pi_joint_controller_unit.sv
// ----------------------------------------------------------------------------
// cascade_pi_joint_controller_unit
// Multi-axis cascade position/velocity PI controller on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the s_axis channel, one word per request; tuser
// selects a control step or an integral clear. Each word gives one result
// word on m_axis. Coefficients are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i: set axis, then select, then a value write stores it.
// Sequence: a control step on a valid axis walks MUL_P, TV, VE, MUL_I, INC1,
// MUL_DT, INC, CAND, CTAU, OUT; a clear or an out-of-range axis goes straight
// to OUT and gives zeros. A request is taken only while the sequencer idles;
// it walks the single 39x25 multiplier through the position product, the
// integral products and the proportional product.
// Reset: all integrals and coefficients go to zero, the sequencer idles and
// no result is pending.
// Stall: the result register holds while m_axis_tready is low; the next
// request is still taken and worked on, and the sequencer waits at its last
// step until the result register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cascade_pi_joint_controller_unit
  import cpjc_pkg::*;
#(
  parameter int NUM_AXES = 6
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // axis, target_pos, measured_pos, measured_vel, step_time, zero pad
  input  wire logic [127:0] s_axis_tdata,
  // req_type
  input  wire logic         s_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // target_vel, vel_error, integral_out, torque_cmd
  output      logic [127:0] m_axis_tdata,
  // sat_flag
  output      logic         m_axis_tuser
);

  localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic [3:0] NUM_AXES_L = 4'(NUM_AXES);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_P  = 4'd1;
  localparam logic [3:0] ST_TV     = 4'd2;
  localparam logic [3:0] ST_VE     = 4'd3;
  localparam logic [3:0] ST_MUL_I  = 4'd4;
  localparam logic [3:0] ST_INC1   = 4'd5;
  localparam logic [3:0] ST_MUL_DT = 4'd6;
  localparam logic [3:0] ST_INC    = 4'd7;
  localparam logic [3:0] ST_CAND   = 4'd8;
  localparam logic [3:0] ST_CTAU   = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0] state_q, state_d;

  // coefficient tables and integrals
  logic [31:0] pos_kp_q  [NUM_AXES];
  logic [31:0] vel_kp_q  [NUM_AXES];
  logic [31:0] vel_ki_q  [NUM_AXES];
  logic [31:0] vel_lim_q [NUM_AXES];
  logic [31:0] int_lim_q [NUM_AXES];
  logic [31:0] trq_lim_q [NUM_AXES];
  logic signed [31:0] integ_q [NUM_AXES];

  logic [2:0] coef_axis_q, coef_select_q;

  // latched request
  logic [AX_W-1:0]    ax_q;
  logic               zero_q;
  logic signed [32:0] err_q;
  logic signed [31:0] mv_q;
  logic [17:0]        dt_q;
  logic [23:0]        pkp_q, vkp_q, vki_q;
  logic [31:0]        vlim_q, ilim_q, tlim_q;

  // working registers
  logic signed [63:0] prod_q;
  logic signed [31:0] tv_q, ve_q, cand_q;
  logic signed [38:0] inc1_q;
  logic signed [32:0] inc_q;
  logic signed [35:0] prop_q;
  logic               sat_q;

  logic [127:0] m_data_q;
  logic         m_user_q, m_valid_q;

  // input fields
  logic [2:0]         in_axis;
  logic [AX_W-1:0]    in_ax;
  logic signed [31:0] in_tp, in_mp, in_mv;
  logic [23:0]        in_dt;
  logic               in_range, accept, out_free;
  logic [23:0]        dt_c;
  logic [31:0]        pkp_c, vkp_c, vki_c;

  assign in_axis  = s_axis_tdata[2:0];
  assign in_ax    = in_axis[AX_W-1:0];
  assign in_tp    = s_axis_tdata[34:3];
  assign in_mp    = s_axis_tdata[66:35];
  assign in_mv    = s_axis_tdata[98:67];
  assign in_dt    = s_axis_tdata[122:99];
  assign in_range = {1'b0, in_axis} < NUM_AXES_L;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    if (in_dt < DT_LO) begin
      dt_c = DT_LO;
    end else if (in_dt > DT_HI) begin
      dt_c = DT_HI;
    end else begin
      dt_c = in_dt;
    end
    pkp_c = cap_coef(pos_kp_q[in_ax], POS_KP_CAP);
    vkp_c = cap_coef(vel_kp_q[in_ax], VEL_KP_CAP);
    vki_c = cap_coef(vel_ki_q[in_ax], VEL_KI_CAP);
  end

  // shared multiplier
  logic signed [38:0] mul_a;
  logic [23:0]        mul_b;
  logic signed [63:0] mul_p;

  always_comb begin
    case (state_q)
      ST_MUL_I: begin
        mul_a = {{7{ve_q[31]}}, ve_q};
        mul_b = vki_q;
      end
      ST_MUL_DT: begin
        mul_a = inc1_q;
        mul_b = {6'd0, dt_q};
      end
      ST_INC: begin
        mul_a = {{7{ve_q[31]}}, ve_q};
        mul_b = vkp_q;
      end
      default: begin
        mul_a = {{6{err_q[32]}}, err_q};
        mul_b = pkp_q;
      end
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // post-processing of the registered product
  logic signed [47:0] q16_full, tv_full, cand_full, ctau, tq_full, tlim_s;
  logic signed [39:0] q24_full;
  logic signed [32:0] ve_diff;
  logic signed [31:0] ve_sat, integ_rd;
  logic               ctau_hi, ctau_lo, keep;

  assign integ_rd = integ_q[ax_q];

  always_comb begin
    q16_full  = div_q16(prod_q);
    q24_full  = div_q24(prod_q);
    tv_full   = sclamp(q16_full, vlim_q);
    ve_diff   = {tv_q[31], tv_q} - {mv_q[31], mv_q};
    if (ve_diff[32] != ve_diff[31]) begin
      ve_sat = ve_diff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      ve_sat = ve_diff[31:0];
    end
    cand_full = sclamp({{16{integ_rd[31]}}, integ_rd} + {{15{inc_q[32]}}, inc_q}, ilim_q);
    ctau      = {{12{prop_q[35]}}, prop_q} + {{16{cand_q[31]}}, cand_q};
    tlim_s    = $signed({16'd0, tlim_q});
    ctau_hi   = ctau > tlim_s;
    ctau_lo   = ctau < -tlim_s;
    keep      = !(ctau_hi || ctau_lo) || (ctau_hi && ve_q[31])
                || (ctau_lo && !ve_q[31] && (ve_q != 32'sd0));
    tq_full   = sclamp({{12{prop_q[35]}}, prop_q} + {{16{integ_rd[31]}}, integ_rd}, tlim_q);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = (!in_range || s_axis_tuser) ? ST_OUT : ST_MUL_P;
      ST_MUL_P:  state_d = ST_TV;
      ST_TV:     state_d = ST_VE;
      ST_VE:     state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_INC1;
      ST_INC1:   state_d = ST_MUL_DT;
      ST_MUL_DT: state_d = ST_INC;
      ST_INC:    state_d = ST_CAND;
      ST_CAND:   state_d = ST_CTAU;
      ST_CTAU:   state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_axis_q   <= '0;
      coef_select_q <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_kp_q[i]  <= '0;
        vel_kp_q[i]  <= '0;
        vel_ki_q[i]  <= '0;
        vel_lim_q[i] <= '0;
        int_lim_q[i] <= '0;
        trq_lim_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_AXIS:   coef_axis_q   <= cfg_wdata_i[2:0];
        CFG_COEF_SELECT: coef_select_q <= cfg_wdata_i[2:0];
        CFG_COEF_VALUE: begin
          if ({1'b0, coef_axis_q} < NUM_AXES_L) begin
            case (coef_select_q)
              SEL_POS_KP:  pos_kp_q[coef_axis_q[AX_W-1:0]]  <= cfg_wdata_i;
              SEL_VEL_KP:  vel_kp_q[coef_axis_q[AX_W-1:0]]  <= cfg_wdata_i;
              SEL_VEL_KI:  vel_ki_q[coef_axis_q[AX_W-1:0]]  <= cfg_wdata_i;
              SEL_VEL_LIM: vel_lim_q[coef_axis_q[AX_W-1:0]] <= cfg_wdata_i;
              SEL_INT_LIM: int_lim_q[coef_axis_q[AX_W-1:0]] <= cfg_wdata_i;
              SEL_TRQ_LIM: trq_lim_q[coef_axis_q[AX_W-1:0]] <= cfg_wdata_i;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // integral store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        integ_q[i] <= '0;
      end
    end else begin
      if (accept && in_range && (s_axis_tuser == REQ_CLEAR)) begin
        integ_q[in_ax] <= '0;
      end
      if ((state_q == ST_VE) && (vki_q == 24'd0)) begin
        integ_q[ax_q] <= '0;
      end
      if ((state_q == ST_CTAU) && keep) begin
        integ_q[ax_q] <= cand_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q   <= in_ax;
      zero_q <= !in_range || (s_axis_tuser == REQ_CLEAR);
      err_q  <= {in_tp[31], in_tp} - {in_mp[31], in_mp};
      mv_q   <= in_mv;
      dt_q   <= dt_c[17:0];
      pkp_q  <= pkp_c[23:0];
      vkp_q  <= vkp_c[23:0];
      vki_q  <= vki_c[23:0];
      vlim_q <= cap_coef(vel_lim_q[in_ax], VEL_LIM_CAP);
      ilim_q <= cap_coef(int_lim_q[in_ax], TRQ_LIM_CAP);
      tlim_q <= cap_coef(trq_lim_q[in_ax], TRQ_LIM_CAP);
    end
    if ((state_q == ST_MUL_P) || (state_q == ST_MUL_I) || (state_q == ST_MUL_DT)
        || (state_q == ST_INC)) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_TV)   tv_q   <= tv_full[31:0];
    if (state_q == ST_VE)   ve_q   <= ve_sat;
    if (state_q == ST_INC1) inc1_q <= q16_full[38:0];
    if (state_q == ST_INC)  inc_q  <= q24_full[32:0];
    if (state_q == ST_CAND) begin
      cand_q <= cand_full[31:0];
      prop_q <= q16_full[35:0];
    end
    if (state_q == ST_CTAU) sat_q <= ctau_hi || ctau_lo;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      if (zero_q) begin
        m_data_q <= '0;
        m_user_q <= 1'b0;
      end else begin
        m_data_q <= {tq_full[31:0], integ_rd, ve_q, tv_q};
        m_user_q <= sat_q;
      end
    end
  end

endmodule

`default_nettype wire

### tb/cascade_pi_joint_controller_unit_test.sv
// ----------------------------------------------------------------------------
// cascade_pi_joint_controller_unit_test
// Self-checking bench for the cascade PI joint controller: stream requests go
// in with random bursts and gaps, results are checked field by field against
// a cycle-free fixed-point predictor, and the coefficient tables are
// reloaded between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cascade_pi_joint_controller_unit_test;
  import cpjc_pkg::*;

  localparam int N_AXES = 6;
  localparam longint Q16_ONE = 64'sd65536;
  localparam longint Q24_ONE = 64'sd16777216;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [2:0] SEL_BAD_LO = 3'd6;
  localparam logic [2:0] SEL_BAD_HI = 3'd7;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_WORDS = 80;

  typedef struct {
    logic        kind;
    logic [2:0]  axis;
    logic [31:0] tgt_pos;
    logic [31:0] meas_pos;
    logic [31:0] meas_vel;
    logic [23:0] dt;
  } joint_req_t;

  typedef struct {
    logic [31:0] tgt_vel;
    logic [31:0] vel_err;
    logic [31:0] integ;
    logic [31:0] torque;
    logic        sat;
  } joint_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  cascade_pi_joint_controller_unit #(.NUM_AXES(N_AXES)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // controller image
  logic [31:0] gain_table [N_AXES][NCOEF];
  longint      integ_acc [N_AXES];
  logic [2:0]  sel_axis;
  logic [2:0]  sel_coef;

  joint_req_t  req_queue [$];
  joint_res_t  result_due [$];
  joint_req_t  cur_req;
  joint_res_t  want;
  int          req_sent = 0;
  int          req_taken = 0;
  int          fault_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_cycle = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic longint bound(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint gain_at(int ax, logic [2:0] sel, logic [31:0] cap);
    longint v;
    longint c;
    v = longint'(gain_table[ax][sel]);
    c = longint'(cap);
    return (v > c) ? c : v;
  endfunction

  function automatic joint_res_t run_control_law(joint_req_t r);
    joint_res_t o;
    int ax;
    longint tp, mp, mv, dt, pkp, vkp, vki, vlim, ilim, tlim;
    longint tv, ve, inc, cand, prop, ctau, acc, tq;
    bit sat;
    o = '{default: '0};
    ax = int'(r.axis);
    if (ax >= N_AXES) return o;
    if (r.kind == REQ_CLEAR) begin
      integ_acc[ax] = 0;
      return o;
    end
    tp = longint'($signed(r.tgt_pos));
    mp = longint'($signed(r.meas_pos));
    mv = longint'($signed(r.meas_vel));
    dt = bound(longint'(r.dt), longint'(DT_LO), longint'(DT_HI));
    pkp = gain_at(ax, SEL_POS_KP, POS_KP_CAP);
    vkp = gain_at(ax, SEL_VEL_KP, VEL_KP_CAP);
    vki = gain_at(ax, SEL_VEL_KI, VEL_KI_CAP);
    vlim = gain_at(ax, SEL_VEL_LIM, VEL_LIM_CAP);
    ilim = gain_at(ax, SEL_INT_LIM, TRQ_LIM_CAP);
    tlim = gain_at(ax, SEL_TRQ_LIM, TRQ_LIM_CAP);
    tv = bound((pkp * (tp - mp)) / Q16_ONE, -vlim, vlim);
    ve = bound(tv - mv, S32_MIN, S32_MAX);
    if (vki == 0) integ_acc[ax] = 0;
    inc = (vki * ve) / Q16_ONE;
    inc = (inc * dt) / Q24_ONE;
    cand = bound(integ_acc[ax] + inc, -ilim, ilim);
    prop = (vkp * ve) / Q16_ONE;
    ctau = prop + cand;
    sat = (ctau > tlim) || (ctau < -tlim);
    // conditional integration: only move the integral out of saturation
    if (!sat || (ctau > tlim && ve < 0) || (ctau < -tlim && ve > 0)) integ_acc[ax] = cand;
    acc = integ_acc[ax];
    tq = bound(prop + acc, -tlim, tlim);
    o.tgt_vel = tv[31:0];
    o.vel_err = ve[31:0];
    o.integ = acc[31:0];
    o.torque = tq[31:0];
    o.sat = sat;
    return o;
  endfunction

  function automatic logic [31:0] q16(real x);
    return 32'($rtoi(x * 65536.0));
  endfunction

  task automatic flag_error(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fault_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp);
    if (got !== exp) flag_error($sformatf("%s got %h exp %h", name, got, exp));
  endtask

  // ---- config writes, model follows ----
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_COEF_AXIS: begin
        sel_axis = data[2:0];
      end
      CFG_COEF_SELECT: begin
        sel_coef = data[2:0];
      end
      CFG_COEF_VALUE: begin
        if (int'(sel_axis) < N_AXES && int'(sel_coef) < NCOEF)
          gain_table[sel_axis][sel_coef] = data;
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_coef(logic [2:0] ax, logic [2:0] sel, logic [31:0] val);
    write_reg(CFG_COEF_AXIS, ($urandom() & 32'hFFFF_FFF8) | 32'(ax));
    write_reg(CFG_COEF_SELECT, ($urandom() & 32'hFFFF_FFF8) | 32'(sel));
    write_reg(CFG_COEF_VALUE, val);
  endtask

  function automatic logic [31:0] pick_gain(int kind, logic [2:0] sel);
    real span;
    int r;
    if (kind == 1) return 32'hFFFF_FFFF;
    if (kind == 2) return 32'd1;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return $urandom();
    case (sel)
      SEL_POS_KP:  span = 20.0;
      SEL_VEL_KP:  span = 5.0;
      SEL_VEL_KI:  span = 120.0;
      SEL_VEL_LIM: span = 50.0;
      default:     span = 22.0;
    endcase
    return $urandom_range(0, q16(span));
  endfunction

  task automatic load_gains(int kind);
    for (int ax = 0; ax < N_AXES; ax++)
      for (int s = 0; s < NCOEF; s++)
        set_coef(3'(ax), 3'(s), pick_gain(kind, 3'(s)));
  endtask

  // ---- stimulus builders ----
  task automatic push_req(logic kind, logic [2:0] ax, logic [31:0] tp, logic [31:0] mp,
                          logic [31:0] mv, logic [23:0] dt);
    joint_req_t r;
    r.kind = kind;
    r.axis = ax;
    r.tgt_pos = tp;
    r.meas_pos = mp;
    r.meas_vel = mv;
    r.dt = dt;
    req_queue.push_back(r);
  endtask

  task automatic push_random(int n);
    int r;
    logic kind;
    logic [2:0] ax;
    logic [31:0] tp, mp, mv;
    logic [23:0] dt;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      kind = REQ_STEP;
      ax = 3'($urandom_range(0, N_AXES - 1));
      if (r < 6) begin
        ax = 3'($urandom_range(N_AXES, 7));
        kind = $urandom_range(0, 1) ? REQ_CLEAR : REQ_STEP;
      end else if (r < 14) begin
        kind = REQ_CLEAR;
      end
      if ($urandom_range(0, 9) == 0) begin
        tp = $urandom();
        mp = $urandom();
        mv = $urandom();
        dt = 24'($urandom());
      end else begin
        mp = $urandom();
        tp = mp + q16(($itor($urandom_range(0, 600)) - 300.0) / 100.0);
        mv = q16(($itor($urandom_range(0, 1600)) - 800.0) / 100.0);
        dt = 24'($urandom_range(DT_LO, DT_HI));
      end
      push_req(kind, ax, tp, mp, mv, dt);
    end
  endtask

  task automatic drain();
    while (req_queue.size() != 0 || s_axis_tvalid || result_due.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // ---- driver ----
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(s_axis_tvalid && req_taken != req_sent)) begin
        if (gap_left == 0 && req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          s_axis_tdata <= {5'd0, cur_req.dt, cur_req.meas_vel, cur_req.meas_pos,
                           cur_req.tgt_pos, cur_req.axis};
          s_axis_tuser <= cur_req.kind;
          s_axis_tvalid <= 1'b1;
          req_sent++;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0 || req_sent % 160 < 40) ?
                       0 : $urandom_range(1, 14);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // ---- receiver ----
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && req_taken >= 150) begin
        hold_done = 1'b1;
        hold_left = 400;
        m_axis_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 96) % 4)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_due.size() == 0) begin
          flag_error("result word with nothing outstanding");
        end else begin
          want = result_due.pop_front();
          check_field("target_vel", m_axis_tdata[31:0], want.tgt_vel);
          check_field("vel_error", m_axis_tdata[63:32], want.vel_err);
          check_field("integral_out", m_axis_tdata[95:64], want.integ);
          check_field("torque_cmd", m_axis_tdata[127:96], want.torque);
          check_field("sat_flag", {31'd0, m_axis_tuser}, {31'd0, want.sat});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        result_due.push_back(run_control_law(cur_req));
        req_taken++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("cascade_pi_joint_controller_unit_test: errors");
    $finish;
  end

  initial begin
    for (int a = 0; a < N_AXES; a++) begin
      integ_acc[a] = 0;
      for (int s = 0; s < NCOEF; s++) gain_table[a][s] = '0;
    end
    sel_axis = '0;
    sel_coef = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all gains off after reset
    push_req(REQ_STEP, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 24'd0);
    push_req(REQ_STEP, 3'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    push_req(REQ_CLEAR, 3'd5, $urandom(), $urandom(), $urandom(), 24'($urandom()));
    push_req(REQ_STEP, 3'd6, $urandom(), $urandom(), $urandom(), 24'($urandom()));
    push_req(REQ_CLEAR, 3'd7, $urandom(), $urandom(), $urandom(), 24'($urandom()));
    push_req(REQ_STEP, 3'd4, $urandom(), $urandom(), $urandom(), 24'($urandom()));
    drain();

    // hand-tuned axes plus capped and out-of-range writes
    set_coef(3'd0, SEL_POS_KP, q16(10.0));
    set_coef(3'd0, SEL_VEL_KP, q16(2.0));
    set_coef(3'd0, SEL_VEL_KI, q16(50.0));
    set_coef(3'd0, SEL_VEL_LIM, q16(5.0));
    set_coef(3'd0, SEL_INT_LIM, q16(3.0));
    set_coef(3'd0, SEL_TRQ_LIM, q16(4.0));
    for (int s = 0; s < NCOEF; s++)
      set_coef(3'd1, 3'(s), (3'(s) == SEL_VEL_KI) ? 32'd0 : gain_table[0][s]);
    set_coef(3'd2, SEL_POS_KP, q16(10.0));
    set_coef(3'd2, SEL_VEL_KP, q16(0.5));
    set_coef(3'd2, SEL_VEL_KI, VEL_KI_CAP);
    set_coef(3'd2, SEL_VEL_LIM, VEL_LIM_CAP);
    set_coef(3'd2, SEL_INT_LIM, TRQ_LIM_CAP);
    set_coef(3'd2, SEL_TRQ_LIM, q16(10.0));
    set_coef(3'd3, SEL_POS_KP, POS_KP_CAP + 32'd1);
    set_coef(3'd3, SEL_VEL_KP, VEL_KP_CAP + 32'd1);
    set_coef(3'd3, SEL_VEL_KI, VEL_KI_CAP + 32'd1);
    set_coef(3'd3, SEL_VEL_LIM, VEL_LIM_CAP + 32'd1);
    set_coef(3'd3, SEL_INT_LIM, TRQ_LIM_CAP + 32'd1);
    set_coef(3'd3, SEL_TRQ_LIM, TRQ_LIM_CAP + 32'd1);
    for (int s = 0; s < NCOEF; s++) begin
      set_coef(3'd4, 3'(s), pick_gain(0, 3'(s)));
      set_coef(3'd5, 3'(s), 32'hFFFF_FFFF);
    end
    set_coef(3'd6, SEL_POS_KP, $urandom());
    set_coef(3'd7, SEL_VEL_KI, $urandom());
    set_coef(3'd0, SEL_BAD_LO, $urandom());
    set_coef(3'd0, SEL_BAD_HI, $urandom());
    write_reg(CFG_UNUSED, $urandom());

    for (int i = 0; i < 3; i++)
      push_req(REQ_STEP, 3'd0, q16(0.05), 32'd0, q16(0.3), 24'hFF_FFFF);
    push_req(REQ_STEP, 3'd0, q16(1.0), 32'd0, 32'd0, 24'hFF_FFFF);
    push_req(REQ_STEP, 3'd0, q16(-1.0), 32'd0, q16(2.0), 24'hFF_FFFF);
    push_req(REQ_CLEAR, 3'd0, 32'd0, 32'd0, 32'd0, 24'd0);
    push_req(REQ_STEP, 3'd0, q16(-0.02), 32'd0, q16(-0.1), 24'd100000);
    push_req(REQ_STEP, 3'd1, q16(0.05), 32'd0, q16(0.3), 24'hFF_FFFF);
    for (int i = 0; i < 4; i++)
      push_req(REQ_STEP, 3'd2, q16(0.1), 32'd0, 32'd0, 24'hFF_FFFF);
    push_req(REQ_STEP, 3'd2, q16(-0.1), 32'd0, 32'd0, 24'hFF_FFFF);
    push_req(REQ_STEP, 3'd3, q16(0.2), q16(-0.1), q16(1.5), 24'd50000);
    push_req(REQ_STEP, 3'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 24'd0);
    push_req(REQ_STEP, 3'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd0);
    push_req(REQ_STEP, 3'd4, q16(0.3), 32'd0, q16(-0.2), DT_LO - 24'd1);
    push_req(REQ_STEP, 3'd4, q16(-0.3), 32'd0, q16(0.2), DT_HI + 24'd1);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      load_gains((p == 1) ? 1 : (p == 3) ? 2 : 0);
      push_random(PHASE_WORDS);
      drain();
    end

    if (fault_count == 0) begin
      $display("cascade_pi_joint_controller_unit_test: clean");
    end else begin
      $display("cascade_pi_joint_controller_unit_test: errors");
    end
    $finish;
  end

endmodule
